>>> rtl/lwc_pkg.sv
// Package for the Lorenz-style twelve-wheel cipher unit.
// Holds wheel numbering, wheel lengths, field widths and command codes.
// No dependencies; used by lorenz_wheel_cipher_unit and lwc_checker.
package lwc_pkg;

  // Wheel bank geometry
  localparam int unsigned NumWheels = 12;
  localparam int unsigned PinW      = 64;
  localparam int unsigned PosW      = 6;
  localparam int unsigned SelW      = 4;
  localparam int unsigned CharW     = 5;

  // Wheel numbering: chi1-5, psi1-5, then the two motor wheels
  localparam int unsigned ChiBase  = 0;
  localparam int unsigned PsiBase  = 5;
  localparam int unsigned NumChi   = 5;
  localparam int unsigned WheelM37 = 10;
  localparam int unsigned WheelM61 = 11;

  // Stream packing
  localparam int unsigned InDataW  = 72;   // pin_pattern + char_in, padded to bytes
  localparam int unsigned InUserW  = 5;    // cmd + wheel_sel
  localparam int unsigned OutDataW = 8;    // char_out, padded to a byte

  // Fixed wheel lengths, indexed by wheel number
  localparam logic [PosW-1:0] WheelLen [NumWheels] = '{
    6'd41, 6'd31, 6'd29, 6'd26, 6'd23,
    6'd43, 6'd47, 6'd51, 6'd53, 6'd59,
    6'd37, 6'd61
  };

  // Item kinds carried on tuser bit 0
  typedef enum logic {
    CmdEncrypt = 1'b0,
    CmdLoad    = 1'b1
  } cmd_e;

endpackage

>>> rtl/lorenz_wheel_cipher_unit.sv
// Lorenz-style twelve-wheel stream cipher on 5-bit teleprinter characters.
// One stream in, one stream out; wheel state kept in flip-flops.
// Depends on lwc_pkg.

// The unit takes one beat per clock cycle, loads and characters alike, with
// no bubbles while unstalled: the wheels that step are updated in the same
// cycle that a character is accepted, and the enciphered character appears in
// the output register the next cycle. A load beat (tuser cmd = 1) writes the
// pin pattern of the wheel given by wheel_sel and puts that wheel back at
// position 0; it gives no output beat, and a wheel_sel of 12 or more is
// ignored. A character beat (cmd = 0) gives exactly one output beat holding
// char_in XOR (chi key XOR psi key), chi1/psi1 in the top bit, after which
// the chi and m61 wheels step, the psi wheels step when the m37 pin was 1 and
// m37 steps when the m61 pin was 1. Deciphering is the same operation. Every
// wheel must be loaded before the first character. The input is stalled only
// while a result sits in the output register and the sink holds tready low.
module lorenz_wheel_cipher_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // tdata: [63:0] pin_pattern, [68:64] char_in, [71:69] zero
  input  logic [lwc_pkg::InDataW-1:0] s_axis_tdata_i,
  // tuser: [0] cmd, [4:1] wheel_sel
  input  logic [lwc_pkg::InUserW-1:0] s_axis_tuser_i,
  // Output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // tdata: [4:0] char_out, [7:5] zero
  output logic [lwc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Unpacked input fields
  lwc_pkg::cmd_e                 cmd;
  logic [lwc_pkg::SelW-1:0]      wheel_sel;
  logic [lwc_pkg::PinW-1:0]      pin_pattern;
  logic [lwc_pkg::CharW-1:0]     char_in;

  // Wheel state
  logic [lwc_pkg::PinW-1:0]      pins_q [lwc_pkg::NumWheels];
  logic [lwc_pkg::PosW-1:0]      pos_q  [lwc_pkg::NumWheels];
  logic [lwc_pkg::PosW-1:0]      pos_inc [lwc_pkg::NumWheels];
  logic [lwc_pkg::NumWheels-1:0] cur_pin;
  logic [lwc_pkg::NumWheels-1:0] step_en;
  logic [lwc_pkg::NumWheels-1:0] load_hit;

  // Handshake and result
  logic                          in_beat;
  logic                          enc_beat;
  logic                          load_beat;
  logic [lwc_pkg::CharW-1:0]     key;
  logic                          out_valid_q;
  logic [lwc_pkg::CharW-1:0]     out_char_q;

  assign cmd         = lwc_pkg::cmd_e'(s_axis_tuser_i[0]);
  assign wheel_sel   = s_axis_tuser_i[lwc_pkg::SelW:1];
  assign pin_pattern = s_axis_tdata_i[lwc_pkg::PinW-1:0];
  assign char_in     = s_axis_tdata_i[lwc_pkg::PinW +: lwc_pkg::CharW];

  // Accept whenever the output register is empty or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign enc_beat        = in_beat && (cmd == lwc_pkg::CmdEncrypt);
  assign load_beat       = in_beat && (cmd == lwc_pkg::CmdLoad);

  // Current pin and wrapped increment for each wheel
  always_comb begin
    for (int w = 0; w < lwc_pkg::NumWheels; w++) begin
      cur_pin[w]  = pins_q[w][pos_q[w]];
      pos_inc[w]  = (pos_q[w] == lwc_pkg::WheelLen[w] - 6'd1) ? '0 : pos_q[w] + 6'd1;
      load_hit[w] = load_beat && (wheel_sel == lwc_pkg::SelW'(w));
    end
  end

  // Step enables: motor pins sampled before anything moves
  always_comb begin
    step_en = '0;
    for (int w = 0; w < lwc_pkg::NumChi; w++) begin
      step_en[lwc_pkg::ChiBase + w] = 1'b1;
      step_en[lwc_pkg::PsiBase + w] = cur_pin[lwc_pkg::WheelM37];
    end
    step_en[lwc_pkg::WheelM37] = cur_pin[lwc_pkg::WheelM61];
    step_en[lwc_pkg::WheelM61] = 1'b1;
  end

  // Key: chi vector XOR psi vector, wheel 1 in the top bit
  always_comb begin
    key = '0;
    for (int i = 0; i < lwc_pkg::NumChi; i++) begin
      key[lwc_pkg::CharW-1-i] = cur_pin[lwc_pkg::ChiBase + i] ^ cur_pin[lwc_pkg::PsiBase + i];
    end
  end

  // Wheel positions: clear on load, advance on a character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < lwc_pkg::NumWheels; w++) begin
        pos_q[w] <= '0;
      end
    end else begin
      for (int w = 0; w < lwc_pkg::NumWheels; w++) begin
        if (load_hit[w]) begin
          pos_q[w] <= '0;
        end else if (enc_beat && step_en[w]) begin
          pos_q[w] <= pos_inc[w];
        end
      end
    end
  end

  // Pin patterns: written only by a load
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < lwc_pkg::NumWheels; w++) begin
      if (load_hit[w]) begin
        pins_q[w] <= pin_pattern;
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (enc_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (enc_beat) begin
      out_char_q <= char_in ^ key;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(lwc_pkg::OutDataW - lwc_pkg::CharW)'(0), out_char_q};

endmodule

>>> rtl/lwc_checker.sv
// Port-level checker for lorenz_wheel_cipher_unit, bound to the top level.
// Watches the stream handshakes only. Depends on lwc_pkg.
module lwc_port_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic [lwc_pkg::InDataW-1:0]  s_axis_tdata_i,
  input logic [lwc_pkg::InUserW-1:0]  s_axis_tuser_i,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [lwc_pkg::OutDataW-1:0] m_axis_tdata_o
);

  logic in_beat;
  logic out_stall;
  logic enc_in;
  logic load_in;

  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign enc_in    = in_beat && (s_axis_tuser_i[0] == lwc_pkg::CmdEncrypt);
  assign load_in   = in_beat && (s_axis_tuser_i[0] == lwc_pkg::CmdLoad);

  // Hold a stalled output beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled output beat changed");

  // Never stall the input while the output register is empty
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // A fresh output beat comes only from a character beat
  a_out_from_enc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall && !enc_in |=> !m_axis_tvalid_o)
    else $error("output beat without a character beat");

  // A character beat always yields an output beat next cycle
  a_enc_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_in |=> m_axis_tvalid_o)
    else $error("character beat lost");

  // A load beat on an empty or draining output leaves it empty
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_in && !out_stall |=> !m_axis_tvalid_o)
    else $error("load beat produced an output beat");

endmodule

bind lorenz_wheel_cipher_unit lwc_port_checker u_lwc_checker (.*);
